>>> hw/rtl/svsr_pkg.sv
// Shared types, constants and the volume gain table for the stereo volume and
// speed resampler. Used by the shared multiplier and by the top level.
// No dependencies.
package svsr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SPEED_W = 9;
   localparam int VOLUME_W = 7;
   localparam int PHASE_W = 9;
   localparam int WEIGHT_W = 8;

   localparam int FULL_PHASE = 100;
   localparam int GAIN_SHIFT = 15;
   localparam int SPEED_MIN = 10;
   localparam int SPEED_MAX = 400;
   localparam int VOLUME_FULL = 100;

   localparam int GAIN_W = 16;
   localparam int MUL_W = 24;
   localparam int PROD_W = 2 * MUL_W;
   localparam int NUM_W = 24;
   localparam int ABS_W = 22;

   localparam int RECIP_SHIFT = 29;
   localparam int RECIP_W = 23;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(FULL_PHASE) - 64'd1) / 64'(FULL_PHASE));

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE = 2'd2;

   typedef logic [GAIN_W-1:0] gain_table_type [2**VOLUME_W];

   function automatic gain_table_type gain_table_build();
      gain_table_type t;
      int v;
      for (int i = 0; i < 2**VOLUME_W; i++) begin
         v = (i > VOLUME_FULL) ? VOLUME_FULL : i;
         t[i] = GAIN_W'((v * v * (1 << GAIN_SHIFT)) / (VOLUME_FULL * VOLUME_FULL));
      end
      return t;
   endfunction

   localparam gain_table_type GAIN_TABLE = gain_table_build();

   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_req_type;

endpackage

>>> hw/rtl/svsr_mul.sv
// Shared signed multiplier with a registered product.
// Depends on svsr_pkg for the operand struct and widths.
module svsr_mul (
   input  logic                                  clock,
   input  svsr_pkg::mul_req_type                 mul_req,
   output logic signed [svsr_pkg::PROD_W-1:0]    mul_prod
);
   import svsr_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = $signed(mul_req.a) * $signed(mul_req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

>>> hw/rtl/stereo_volume_speed_resampler_top.sv
// Stereo volume and speed resampler: scales each source frame by a squared-law
// volume and emits linearly interpolated output frames at the programmed speed.
// Depends on svsr_pkg and svsr_mul.

// One source frame is taken per item while req_tready is high. Every product,
// both the volume scaling and the interpolation terms and the division by one
// hundred done as a reciprocal multiply, goes through a single shared 24 by 24
// bit multiplier. An item scales both channels, then makes n output frames,
// n from 0 to 10: per channel the previous and current samples are weighted,
// summed, multiplied by the reciprocal and the quotient taken (three multiplier
// passes), then the frame is presented and the output side may stall it. The
// input side is not ready while an item is at work. Configuration writes are
// always accepted and must only be made while idle.
module stereo_volume_speed_resampler_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // left_in, right_in
   input  logic                                req_tuser,   // restart
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [31:0]                         rsp_tdata,   // left_out, right_out
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [svsr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [svsr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import svsr_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SCL_L  = 4'd1;
   localparam logic [3:0] ST_SCL_R  = 4'd2;
   localparam logic [3:0] ST_DECIDE = 4'd3;
   localparam logic [3:0] ST_MUL_A  = 4'd4;
   localparam logic [3:0] ST_MUL_B  = 4'd5;
   localparam logic [3:0] ST_SUM    = 4'd6;
   localparam logic [3:0] ST_MUL_Q  = 4'd7;
   localparam logic [3:0] ST_QUOT   = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   logic [3:0]                 state_ff, state_in;
   logic [SPEED_W-1:0]         speed_ff, speed_in;
   logic [VOLUME_W-1:0]        volume_ff, volume_in;
   logic                       mute_ff, mute_in;
   logic signed [SAMPLE_W-1:0] prev_l_ff, prev_l_in;
   logic signed [SAMPLE_W-1:0] prev_r_ff, prev_r_in;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic                       have_prev_ff, have_prev_in;

   logic signed [SAMPLE_W-1:0] in_l_ff, in_l_in;
   logic signed [SAMPLE_W-1:0] in_r_ff, in_r_in;
   logic signed [SAMPLE_W-1:0] cur_l_ff, cur_l_in;
   logic signed [SAMPLE_W-1:0] cur_r_ff, cur_r_in;
   logic signed [NUM_W-1:0]    acc_ff, acc_in;
   logic [ABS_W-1:0]           absn_ff, absn_in;
   logic                       neg_ff, neg_in;
   logic                       chan_ff, chan_in;
   logic signed [SAMPLE_W-1:0] out_l_ff, out_l_in;
   logic signed [SAMPLE_W-1:0] out_r_ff, out_r_in;
   logic                       last_ff, last_in;

   mul_req_type                mul_req;
   logic signed [PROD_W-1:0]   prod;

   logic                       req_fire;
   logic                       rsp_fire;
   logic                       vol_zero;
   logic                       vol_unity;
   logic [GAIN_W-1:0]          gain;
   logic [SPEED_W-1:0]         step;
   logic [PHASE_W:0]           phase_step;
   logic [PHASE_W:0]           phase_wrap;
   logic [WEIGHT_W-1:0]        weight_prev;
   logic [WEIGHT_W-1:0]        weight_cur;
   logic signed [SAMPLE_W-1:0] sel_prev;
   logic signed [SAMPLE_W-1:0] sel_cur;
   logic signed [SAMPLE_W-1:0] scaled;
   logic signed [SAMPLE_W-1:0] scale_src;
   logic signed [NUM_W-1:0]    num;
   logic signed [NUM_W-1:0]    num_neg;
   logic [SAMPLE_W-1:0]        quot;
   logic signed [SAMPLE_W:0]   quot_s;
   logic signed [SAMPLE_W:0]   quot_signed;
   logic signed [SAMPLE_W-1:0] interp;

   svsr_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (prod)
   );

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign csr_ready = 1'b1;
   assign rsp_tdata = {out_r_ff, out_l_ff};
   assign rsp_tlast = last_ff;

   assign vol_zero = mute_ff || (volume_ff == '0);
   assign vol_unity = (volume_ff >= VOLUME_W'(VOLUME_FULL));
   assign gain = GAIN_TABLE[volume_ff];

   always_comb begin
      priority if (speed_ff < SPEED_W'(SPEED_MIN)) begin
         step = SPEED_W'(SPEED_MIN);
      end else if (speed_ff > SPEED_W'(SPEED_MAX)) begin
         step = SPEED_W'(SPEED_MAX);
      end else begin
         step = speed_ff;
      end
   end

   assign phase_step = {1'b0, phase_ff} + {1'b0, step};
   assign phase_wrap = phase_step - (PHASE_W + 1)'(FULL_PHASE);
   assign weight_cur = {1'b0, phase_ff[WEIGHT_W-2:0]};
   assign weight_prev = WEIGHT_W'(FULL_PHASE) - weight_cur;
   assign sel_prev = chan_ff ? prev_r_ff : prev_l_ff;
   assign sel_cur = chan_ff ? cur_r_ff : cur_l_ff;

   assign scale_src = (state_ff == ST_SCL_R) ? in_l_ff : in_r_ff;
   always_comb begin
      priority if (vol_zero) begin
         scaled = '0;
      end else if (vol_unity) begin
         scaled = scale_src;
      end else begin
         scaled = prod[GAIN_SHIFT+SAMPLE_W-1:GAIN_SHIFT];
      end
   end

   assign num = acc_ff + prod[NUM_W-1:0];
   assign num_neg = -num;
   assign quot = prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
   assign quot_s = {1'b0, quot};
   assign quot_signed = neg_ff ? -quot_s : quot_s;
   always_comb begin
      priority if (quot_signed > (SAMPLE_W + 1)'(32767)) begin
         interp = 16'sh7fff;
      end else begin
         interp = quot_signed[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      mul_req.a = '0;
      mul_req.b = '0;
      unique case (state_ff)
         ST_SCL_L: begin
            mul_req.a = {{(MUL_W-SAMPLE_W){in_l_ff[SAMPLE_W-1]}}, in_l_ff};
            mul_req.b = {{(MUL_W-GAIN_W){1'b0}}, gain};
         end
         ST_SCL_R: begin
            mul_req.a = {{(MUL_W-SAMPLE_W){in_r_ff[SAMPLE_W-1]}}, in_r_ff};
            mul_req.b = {{(MUL_W-GAIN_W){1'b0}}, gain};
         end
         ST_MUL_A: begin
            mul_req.a = {{(MUL_W-SAMPLE_W){sel_prev[SAMPLE_W-1]}}, sel_prev};
            mul_req.b = {{(MUL_W-WEIGHT_W){1'b0}}, weight_prev};
         end
         ST_MUL_B: begin
            mul_req.a = {{(MUL_W-SAMPLE_W){sel_cur[SAMPLE_W-1]}}, sel_cur};
            mul_req.b = {{(MUL_W-WEIGHT_W){1'b0}}, weight_cur};
         end
         ST_MUL_Q: begin
            mul_req.a = {{(MUL_W-ABS_W){1'b0}}, absn_ff};
            mul_req.b = {{(MUL_W-RECIP_W){1'b0}}, RECIP};
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      speed_in = speed_ff;
      volume_in = volume_ff;
      mute_in = mute_ff;
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      phase_in = phase_ff;
      have_prev_in = have_prev_ff;
      in_l_in = in_l_ff;
      in_r_in = in_r_ff;
      cur_l_in = cur_l_ff;
      cur_r_in = cur_r_ff;
      acc_in = acc_ff;
      absn_in = absn_ff;
      neg_in = neg_ff;
      chan_in = chan_ff;
      out_l_in = out_l_ff;
      out_r_in = out_r_ff;
      last_in = last_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPEED:  speed_in = csr_wdata[SPEED_W-1:0];
            CSR_VOLUME: volume_in = csr_wdata[VOLUME_W-1:0];
            CSR_MUTE:   mute_in = csr_wdata[0];
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               in_l_in = req_tdata[SAMPLE_W-1:0];
               in_r_in = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
               if (req_tuser) begin
                  prev_l_in = '0;
                  prev_r_in = '0;
                  phase_in = '0;
                  have_prev_in = 1'b0;
               end
               state_in = ST_SCL_L;
            end
         end
         ST_SCL_L: state_in = ST_SCL_R;
         ST_SCL_R: begin
            cur_l_in = scaled;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cur_r_in = scaled;
            chan_in = 1'b0;
            priority if (!have_prev_ff) begin
               prev_l_in = cur_l_ff;
               prev_r_in = scaled;
               have_prev_in = 1'b1;
               state_in = ST_IDLE;
            end else if (phase_ff >= PHASE_W'(FULL_PHASE)) begin
               prev_l_in = cur_l_ff;
               prev_r_in = scaled;
               phase_in = phase_ff - PHASE_W'(FULL_PHASE);
               state_in = ST_IDLE;
            end else begin
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: begin
            acc_in = prod[NUM_W-1:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            neg_in = num[NUM_W-1];
            absn_in = num[NUM_W-1] ? num_neg[ABS_W-1:0] : num[ABS_W-1:0];
            state_in = ST_MUL_Q;
         end
         ST_MUL_Q: state_in = ST_QUOT;
         ST_QUOT: begin
            if (chan_ff) begin
               out_r_in = interp;
               last_in = (phase_step >= (PHASE_W + 1)'(FULL_PHASE));
               state_in = ST_OUT;
            end else begin
               out_l_in = interp;
               chan_in = 1'b1;
               state_in = ST_MUL_A;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               chan_in = 1'b0;
               if (last_ff) begin
                  phase_in = phase_wrap[PHASE_W-1:0];
                  prev_l_in = cur_l_ff;
                  prev_r_in = cur_r_ff;
                  state_in = ST_IDLE;
               end else begin
                  phase_in = phase_step[PHASE_W-1:0];
                  state_in = ST_MUL_A;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         speed_ff <= SPEED_W'(FULL_PHASE);
         volume_ff <= VOLUME_W'(VOLUME_FULL);
         mute_ff <= 1'b0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         phase_ff <= '0;
         have_prev_ff <= 1'b0;
         chan_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         speed_ff <= speed_in;
         volume_ff <= volume_in;
         mute_ff <= mute_in;
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
         phase_ff <= phase_in;
         have_prev_ff <= have_prev_in;
         chan_ff <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      in_l_ff <= in_l_in;
      in_r_ff <= in_r_in;
      cur_l_ff <= cur_l_in;
      cur_r_ff <= cur_r_in;
      acc_ff <= acc_in;
      absn_ff <= absn_in;
      neg_ff <= neg_in;
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
      last_ff <= last_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while an output item is pending");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PHASE_W'(SPEED_MAX))
      else $error("phase left its range");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_tlast |=> req_tready)
      else $error("sequencer did not return to idle after the final output item");

   a_out_needs_prev: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> have_prev_ff)
      else $error("output item without a previous frame");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input side ready right after an accepted item");

endmodule
